/* design/ctc_pkg.sv */
package ctc_pkg;

  localparam int TOKEN_LIMIT        = 8;
  localparam int KEYWORD_COUNT      = 2;
  localparam int KEYWORD_MAX_LENGTH = 8;
  localparam int KW_ROWS            = 8;
  localparam int KW_ROW_W           = $clog2(KW_ROWS);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [3:0] POS_MAX     = 4'd15;
  localparam logic [3:0] HEX_MIN_LEN = 4'd3;
  localparam logic [3:0] HEX_MAX_LEN = 4'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_STRING  = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        keyword_code;
    logic [15:0] number_value;
    logic [3:0]  token_index;
    logic        last;
  } res_t;

  // keyword strings: row 0 callib, row 1 goto, other rows empty
  function automatic logic [7:0] kw_char(input logic [KW_ROW_W-1:0] row,
                                         input logic [3:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    case (row)
      3'd0: begin
        case (pos)
          4'd0:    ch = 8'h63;
          4'd1:    ch = 8'h61;
          4'd2:    ch = 8'h6c;
          4'd3:    ch = 8'h6c;
          4'd4:    ch = 8'h69;
          4'd5:    ch = 8'h62;
          default: ch = CH_NUL;
        endcase
      end
      3'd1: begin
        case (pos)
          4'd0:    ch = 8'h67;
          4'd1:    ch = 8'h6f;
          4'd2:    ch = 8'h74;
          4'd3:    ch = 8'h6f;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] kw_len(input logic [KW_ROW_W-1:0] row);
    logic [3:0] raw;
    case (row)
      3'd0:    raw = 4'd6;
      3'd1:    raw = 4'd4;
      default: raw = 4'd0;
    endcase
    if (raw > 4'(KEYWORD_MAX_LENGTH)) raw = 4'(KEYWORD_MAX_LENGTH);
    return raw;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + DIGIT_TEN)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + DIGIT_TEN)};
    end
    return r;
  endfunction

endpackage

/* design/ctc_if.sv */
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface ctc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        keyword_code;
  logic [15:0] number_value;
  logic [3:0]  token_index;
  logic        last;
  modport source (output valid, output kind, output keyword_code, output number_value,
                  output token_index, output last, input ready);
  modport sink (input valid, input kind, input keyword_code, input number_value,
                input token_index, input last, output ready);
endinterface

interface ctc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] delimiter_char;
  modport source (output valid, output delimiter_char, input ready);
  modport sink (input valid, input delimiter_char, output ready);
endinterface

/* design/command_token_classifier.sv */
// command_token_classifier
//
// in_s carries one message character per transfer; a zero byte ends the
// message. out_s carries one result per transfer: the class of each token
// (keyword, hex number or plain string) as soon as its closing delimiter or
// zero byte arrives, then an end item with the token count and last set.
// cfg_s writes the delimiter character; it is always ready and is meant to
// be written while no message is in flight.
//
// Throughput is one character per cycle while in_s.ready is high. A result is
// in the output queue the cycle after the character that causes it; a zero
// byte inside a token yields two results, pushed into the queue together.
// Results sit in a four-entry output queue, and in_s.ready is high while the
// queue holds at most two entries, so a stalled receiver holds back the
// input once more than two entries wait, so the queue never overflows.
// Reset returns the delimiter to space, empties the queue and clears the
// token state; the block also clears its token state after every message.
module command_token_classifier #(
  parameter int KEYWORD_COUNT = ctc_pkg::KEYWORD_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  ctc_in_if.sink    in_s,
  ctc_out_if.source out_s,
  ctc_cfg_if.sink   cfg_s
);

  logic [7:0]               delim_r;
  logic                     in_token_r, in_token_nxt;
  logic [3:0]               token_count_r, token_count_nxt;
  logic [3:0]               char_pos_r, char_pos_nxt;
  logic [KEYWORD_COUNT-1:0] kw_match_r, kw_match_nxt;
  logic [15:0]              hex_acc_r, hex_acc_nxt;
  logic                     hex_ok_r, hex_ok_nxt;

  ctc_pkg::res_t oq_r [ctc_pkg::OQ_DEPTH];
  logic [ctc_pkg::OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ctc_pkg::OQ_AW:0]   cnt_r;

  logic          in_acc, pop;
  logic [7:0]    c;
  logic          kw_hit;
  logic          kw_code;
  ctc_pkg::res_t tok_res, end_res, push_a, push_b;
  logic [1:0]    push_n;
  logic [3:0]    p;
  logic [4:0]    hd;

  assign c      = in_s.char_code;
  assign in_acc = in_s.valid && in_s.ready;
  assign pop    = out_s.valid && out_s.ready;

  assign in_s.ready  = (cnt_r <= (ctc_pkg::OQ_AW + 1)'(ctc_pkg::OQ_DEPTH - 2));
  assign cfg_s.ready = 1'b1;

  // classification of the token that is open now
  always_comb begin
    kw_hit  = 1'b0;
    kw_code = 1'b0;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (kw_match_r[i] && ctc_pkg::kw_len(ctc_pkg::KW_ROW_W'(i)) == char_pos_r) begin
        kw_hit  = 1'b1;
        kw_code = 1'(i);
      end
    end
  end

  always_comb begin
    tok_res              = '0;
    tok_res.token_index  = token_count_r - 4'd1;
    if (kw_hit) begin
      tok_res.kind         = ctc_pkg::KIND_KEYWORD;
      tok_res.keyword_code = kw_code;
    end else if (hex_ok_r &&
                 (char_pos_r inside {[ctc_pkg::HEX_MIN_LEN:ctc_pkg::HEX_MAX_LEN]})) begin
      tok_res.kind         = ctc_pkg::KIND_NUMBER;
      tok_res.number_value = hex_acc_r;
    end else begin
      tok_res.kind = ctc_pkg::KIND_STRING;
    end
    end_res             = '0;
    end_res.kind        = ctc_pkg::KIND_END;
    end_res.token_index = token_count_r;
    end_res.last        = 1'b1;
  end

  // next token state and pushed results
  always_comb begin
    in_token_nxt    = in_token_r;
    token_count_nxt = token_count_r;
    char_pos_nxt    = char_pos_r;
    kw_match_nxt    = kw_match_r;
    hex_acc_nxt     = hex_acc_r;
    hex_ok_nxt      = hex_ok_r;
    push_n          = 2'd0;
    push_a          = tok_res;
    push_b          = end_res;
    p               = char_pos_r;
    hd              = ctc_pkg::hex_digit(c);
    if (in_acc) begin
      if (c == ctc_pkg::CH_NUL) begin
        if (in_token_r) begin
          push_n = 2'd2;
        end else begin
          push_n = 2'd1;
          push_a = end_res;
        end
        in_token_nxt    = 1'b0;
        token_count_nxt = 4'd0;
        char_pos_nxt    = 4'd0;
        kw_match_nxt    = '1;
        hex_acc_nxt     = 16'd0;
        hex_ok_nxt      = 1'b1;
      end else if (c == delim_r) begin
        if (in_token_r) begin
          push_n = 2'd1;
        end
        in_token_nxt = 1'b0;
      end else if (in_token_r || token_count_r < 4'(ctc_pkg::TOKEN_LIMIT)) begin
        if (!in_token_r) begin
          in_token_nxt    = 1'b1;
          token_count_nxt = token_count_r + 4'd1;
          p               = 4'd0;
          kw_match_nxt    = '1;
          hex_acc_nxt     = 16'd0;
          hex_ok_nxt      = 1'b1;
        end
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
          if (p >= ctc_pkg::kw_len(ctc_pkg::KW_ROW_W'(i)) ||
              ctc_pkg::kw_char(ctc_pkg::KW_ROW_W'(i), p) != c) begin
            kw_match_nxt[i] = 1'b0;
          end
        end
        if (p == 4'd0) begin
          if (c != ctc_pkg::CH_0) hex_ok_nxt = 1'b0;
        end else if (p == 4'd1) begin
          if (c != ctc_pkg::CH_X) hex_ok_nxt = 1'b0;
        end else if (p >= ctc_pkg::HEX_MAX_LEN) begin
          hex_ok_nxt = 1'b0;
        end else begin
          if (!hd[4]) hex_ok_nxt = 1'b0;
          hex_acc_nxt = {hex_acc_nxt[11:0], hd[3:0]};
        end
        char_pos_nxt = (p == ctc_pkg::POS_MAX) ? p : p + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r       <= ctc_pkg::CH_SPACE;
      in_token_r    <= 1'b0;
      token_count_r <= 4'd0;
      char_pos_r    <= 4'd0;
      kw_match_r    <= '1;
      hex_acc_r     <= 16'd0;
      hex_ok_r      <= 1'b1;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_s.valid && cfg_s.ready) begin
        delim_r <= cfg_s.delimiter_char;
      end
      in_token_r    <= in_token_nxt;
      token_count_r <= token_count_nxt;
      char_pos_r    <= char_pos_nxt;
      kw_match_r    <= kw_match_nxt;
      hex_acc_r     <= hex_acc_nxt;
      hex_ok_r      <= hex_ok_nxt;
      wr_ptr_r      <= wr_ptr_r + ctc_pkg::OQ_AW'(push_n);
      rd_ptr_r      <= rd_ptr_r + ctc_pkg::OQ_AW'(pop);
      cnt_r         <= cnt_r + (ctc_pkg::OQ_AW + 1)'(push_n)
                             - (ctc_pkg::OQ_AW + 1)'(pop);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      oq_r[wr_ptr_r + 1'b1] <= push_b;
    end
  end

  assign out_s.valid        = (cnt_r != '0);
  assign out_s.kind         = oq_r[rd_ptr_r].kind;
  assign out_s.keyword_code = oq_r[rd_ptr_r].keyword_code;
  assign out_s.number_value = oq_r[rd_ptr_r].number_value;
  assign out_s.token_index  = oq_r[rd_ptr_r].token_index;
  assign out_s.last         = oq_r[rd_ptr_r].last;

endmodule

/* design/ctc_checker.sv */
module ctc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic        out_keyword_code,
  input logic [15:0] out_number_value,
  input logic [3:0]  out_token_index,
  input logic        out_last
);

  // queue is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // a message end always produces a result on the next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char_code == ctc_pkg::CH_NUL) |=> out_valid)
    else $error("no result after message end");

  // token results never index past the token limit
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_token_index < 4'(ctc_pkg::TOKEN_LIMIT)))
    else $error("token index beyond limit");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_kind) && $stable(out_keyword_code) &&
      $stable(out_number_value) && $stable(out_token_index) && $stable(out_last)))
    else $error("result changed while stalled");

endmodule

bind command_token_classifier ctc_checker u_ctc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .in_char_code     (in_s.char_code),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .out_kind         (out_s.kind),
  .out_keyword_code (out_s.keyword_code),
  .out_number_value (out_s.number_value),
  .out_token_index  (out_s.token_index),
  .out_last         (out_s.last)
);
